// ----- hdl/rmw_pkg.sv -----
// ----------------------------------------------------------------------------
// rmw_pkg
// Shared types, register indexes, constants and the sine table generator for
// the multi-wave ring modulator.
// ----------------------------------------------------------------------------
package rmw_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MIX_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam int PHASE_BITS_DEF = 32;
	localparam int SINE_ENTRIES_DEF = 1024;

	localparam logic [MIX_W-1:0] MIX_ONE = 16'h8000;
	localparam logic [CFG_DATA_W-1:0] STEP_RESET = 32'd39370534;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEXT_SHAPE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX = 8'd2;

	typedef enum logic [1:0] {
		SHAPE_SINE = 2'd0,
		SHAPE_SAW = 2'd1,
		SHAPE_SQUARE = 2'd2,
		SHAPE_TRIANGLE = 2'd3
	} shape_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic signed [SAMPLE_W-1:0] carrier_sample;
	} result_t;

	// What every lane needs besides its own dry sample.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] carrier;
		logic [MIX_W-1:0] mix;
		logic [MIX_W-1:0] mix_inv;
	} lane_ctl_t;

	localparam longint Q30 = 64'sd1073741824;
	localparam longint C1 = 64'sd1686629713;
	localparam longint C3 = -64'sd693598668;
	localparam longint C5 = 64'sd85569306;
	localparam longint C7 = -64'sd5026995;
	localparam longint C9 = 64'sd172272;
	localparam longint FULL_M1 = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;

	// Quarter-wave sine entry from an odd Q30 polynomial. The entry count is
	// a power of two, so the Q30 angle is the index shifted left by shl.
	// Divisions truncate toward zero, as the fixed-point recipe requires.
	function automatic logic [SAMPLE_W-2:0] sine_entry(input int idx, input int shl);
		longint x;
		longint x2;
		longint t;
		longint y;
		x = longint'(idx) <<< shl;
		x2 = (x * x) / Q30;
		t = C9;
		t = C7 + (t * x2) / Q30;
		t = C5 + (t * x2) / Q30;
		t = C3 + (t * x2) / Q30;
		t = C1 + (t * x2) / Q30;
		y = (t * x) / Q30;
		if (y < 0) begin
			y = 0;
		end
		y = (y * FULL_M1 + Q30 / 2) / Q30;
		if (y > FULL_M1) begin
			y = FULL_M1;
		end
		return y[SAMPLE_W-2:0];
	endfunction

endpackage

// ----- hdl/rmw_sine_rom.sv -----
// ----------------------------------------------------------------------------
// rmw_sine_rom
// Quarter-wave sine table, one entry past the quarter, with registered read.
// ----------------------------------------------------------------------------
module rmw_sine_rom #(
	parameter int SINE_ENTRIES = rmw_pkg::SINE_ENTRIES_DEF
) (
	input logic clk,
	input logic en,
	input logic [$clog2(SINE_ENTRIES):0] addr,
	output logic [rmw_pkg::SAMPLE_W-2:0] data
);
	import rmw_pkg::*;

	localparam int IW = $clog2(SINE_ENTRIES);

	typedef logic [SAMPLE_W-2:0] rom_arr_t [SINE_ENTRIES+1];

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int i = 0; i <= SINE_ENTRIES; i++) begin
			r[i] = sine_entry(i, 30 - IW);
		end
		return r;
	endfunction

	localparam rom_arr_t ROM = build_rom();

	logic [SAMPLE_W-2:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= ROM[addr];
		end
	end

	assign data = data_q;

endmodule

// ----- hdl/rmw_nco.sv -----
// ----------------------------------------------------------------------------
// rmw_nco
// Phase accumulator and carrier generator: sine, saw, square or triangle.
// The carrier for a word leaves three pipeline stages after its phase.
// ----------------------------------------------------------------------------
module rmw_nco #(
	parameter int PHASE_BITS = rmw_pkg::PHASE_BITS_DEF,
	parameter int SINE_ENTRIES = rmw_pkg::SINE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic load,
	input logic [rmw_pkg::CFG_DATA_W-1:0] step,
	input rmw_pkg::shape_t next_shape,
	output logic signed [rmw_pkg::SAMPLE_W-1:0] carrier
);
	import rmw_pkg::*;

	localparam int PB = PHASE_BITS;
	localparam int SW = SAMPLE_W;
	localparam int IW = $clog2(SINE_ENTRIES);
	localparam int PX = (PB > SW + 1) ? PB : SW + 1;

	localparam logic signed [SW-1:0] SQ_HI = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SQ_LO = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW+1:0] TRI_F = (SW+2)'(1 << (SW - 1));
	localparam logic signed [SW+1:0] TRI_3F = (SW+2)'(3 << (SW - 1));
	localparam logic signed [SW+1:0] TRI_MAX = TRI_F - (SW+2)'(1);

	logic [PB-1:0] phase_acc_q;
	shape_t active_shape_q;
	logic [PB:0] sum;

	logic [PB-1:0] phase_s1;
	shape_t shape_s1;

	logic [1:0] quad;
	logic [IW-1:0] idx;
	logic [IW:0] rom_addr;
	logic [SW-2:0] rom_data;
	logic [PX-1:0] pe;
	logic [SW:0] tri_t;
	logic signed [SW+1:0] tri_w;
	logic signed [SW-1:0] tri_v;
	logic signed [SW-1:0] other;

	logic signed [SW-1:0] other_s2;
	logic neg_s2;
	shape_t shape_s2;
	logic signed [SW-1:0] sine_v;
	logic signed [SW-1:0] carrier_s3;

	assign sum = {1'b0, phase_acc_q} + {1'b0, PB'(step)};

	// A carry out of the phase add is the wrap that lets a new shape in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			active_shape_q <= SHAPE_SINE;
		end else if (load) begin
			phase_acc_q <= sum[PB-1:0];
			if (sum[PB]) begin
				active_shape_q <= next_shape;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= phase_acc_q;
			shape_s1 <= active_shape_q;
		end
	end

	assign quad = phase_s1[PB-1:PB-2];
	assign idx = phase_s1[PB-3 -: IW];
	assign rom_addr = quad[0] ? ((IW+1)'(SINE_ENTRIES) - {1'b0, idx}) : {1'b0, idx};

	rmw_sine_rom #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_rom (
		.clk(clk),
		.en(en),
		.addr(rom_addr),
		.data(rom_data)
	);

	// Phase left-aligned in a word wide enough for the triangle's extra bit.
	assign pe = PX'(phase_s1) << (PX - PB);
	assign tri_t = pe[PX-1 -: SW+1];

	always_comb begin
		if (!phase_s1[PB-1]) begin
			tri_w = $signed({1'b0, tri_t}) - TRI_F;
		end else begin
			tri_w = TRI_3F - $signed({1'b0, tri_t});
		end
		if (tri_w > TRI_MAX) begin
			tri_v = SQ_HI;
		end else begin
			tri_v = tri_w[SW-1:0];
		end
	end

	always_comb begin
		case (shape_s1)
			SHAPE_SAW: other = {~pe[PX-1], pe[PX-2 -: SW-1]};
			SHAPE_SQUARE: other = phase_s1[PB-1] ? SQ_LO : SQ_HI;
			SHAPE_TRIANGLE: other = tri_v;
			default: other = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			other_s2 <= other;
			neg_s2 <= quad[1];
			shape_s2 <= shape_s1;
		end
	end

	assign sine_v = $signed({1'b0, rom_data});

	always_ff @(posedge clk) begin
		if (en) begin
			if (shape_s2 == SHAPE_SINE) begin
				carrier_s3 <= neg_s2 ? -sine_v : sine_v;
			end else begin
				carrier_s3 <= other_s2;
			end
		end
	end

	assign carrier = carrier_s3;

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(phase_acc_q))
		else $error("phase moved without an accepted word");

	a_shape_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(active_shape_q))
		else $error("shape changed without an accepted word");

	a_square_levels: assert property (@(posedge clk) disable iff (!arst_n)
		en && shape_s1 == SHAPE_SQUARE |=> other_s2 == SQ_HI || other_s2 == SQ_LO)
		else $error("square carrier off its two levels");

endmodule

// ----- hdl/rmw_lane.sv -----
// ----------------------------------------------------------------------------
// rmw_lane
// One channel: ring product, dry/wet blend, rounding and saturation.
// Two pipeline stages; the result is combinational off the second.
// ----------------------------------------------------------------------------
module rmw_lane (
	input logic clk,
	input logic en,
	input logic signed [rmw_pkg::SAMPLE_W-1:0] dry,
	input rmw_pkg::lane_ctl_t ctl,
	output logic signed [rmw_pkg::SAMPLE_W-1:0] sample_out
);
	import rmw_pkg::*;

	localparam int SW = SAMPLE_W;
	localparam int PW = 2 * SW;
	localparam int DW = SW + MIX_W + 1;
	localparam int AW = 2 * SW + MIX_W;
	localparam int RS = SW - 1 + MIX_W - 1;
	localparam int OW = AW - RS;

	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (RS - 1);
	localparam logic signed [OW-1:0] HI = OW'((1 << (SW - 1)) - 1);
	localparam logic signed [OW-1:0] LO = -HI - OW'(1);

	logic signed [PW-1:0] wet_s4;
	logic signed [DW-1:0] dw_s4;
	logic [MIX_W-1:0] mix_s4;
	logic signed [AW-1:0] acc_s5;
	logic signed [AW-1:0] rnd;
	logic signed [OW-1:0] shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			wet_s4 <= dry * ctl.carrier;
			dw_s4 <= dry * $signed({1'b0, ctl.mix_inv});
			mix_s4 <= ctl.mix;
		end
	end

	// The dry term is scaled up by full scale so both terms share one binary point.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s5 <= (AW'(dw_s4) <<< (SW - 1)) + AW'(wet_s4) * $signed({1'b0, mix_s4});
		end
	end

	assign rnd = acc_s5 + HALF;
	assign shifted = $signed(rnd[AW-1:RS]);

	always_comb begin
		if (shifted > HI) begin
			sample_out = HI[SW-1:0];
		end else if (shifted < LO) begin
			sample_out = LO[SW-1:0];
		end else begin
			sample_out = shifted[SW-1:0];
		end
	end

endmodule

// ----- hdl/ring_modulator_multi_wave.sv -----
// ----------------------------------------------------------------------------
// ring_modulator_multi_wave
// Stereo ring modulator with a sine, saw, square or triangle carrier and a
// linear dry/wet blend. Two channel lanes share one carrier generator.
//
//   channel   signals                                   direction
//   sample    sample_valid, sample_ready, sample        in
//   result    result_valid, result_ready, result        out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in (always ready)
//
// One word is accepted per cycle while no result waits at the output; its result passes
// the carrier path (phase register, table read, sign), the two multiply stages and the output register.
// The whole pipeline holds while a result waits on result_ready.
// Reset clears the phase to zero, selects sine and loads the register
// defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module ring_modulator_multi_wave #(
	parameter int PHASE_BITS = rmw_pkg::PHASE_BITS_DEF,
	parameter int SINE_ENTRIES = rmw_pkg::SINE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input rmw_pkg::sample_t sample,
	output logic result_valid,
	input logic result_ready,
	output rmw_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rmw_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rmw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rmw_pkg::*;

	localparam int SW = SAMPLE_W;

	logic [CFG_DATA_W-1:0] step_q;
	shape_t next_shape_q;
	logic [MIX_W-1:0] wet_mix_q;

	logic en;
	logic load;
	logic [MIX_W-1:0] mix_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic result_valid_q;
	result_t result_q;

	sample_t dry_s1, dry_s2, dry_s3;
	logic [MIX_W-1:0] mix_s1, mix_s2, mix_s3;
	logic [MIX_W-1:0] inv_s1, inv_s2, inv_s3;
	logic signed [SW-1:0] carrier_s3, carrier_s4, carrier_s5;
	lane_ctl_t ctl;
	logic signed [SW-1:0] left_res, right_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			next_shape_q <= SHAPE_SINE;
			wet_mix_q <= MIX_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PHASE_STEP: step_q <= cfg_data;
				REG_NEXT_SHAPE: next_shape_q <= shape_t'(cfg_data[1:0]);
				REG_WET_MIX: wet_mix_q <= cfg_data[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Everything advances together unless a finished word is stuck at the output.
	assign en = !result_valid_q || result_ready;
	assign sample_ready = en;
	assign load = sample_valid && en;

	assign mix_c = (wet_mix_q > MIX_ONE) ? MIX_ONE : wet_mix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			result_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dry_s1 <= sample;
			mix_s1 <= mix_c;
			inv_s1 <= MIX_ONE - mix_c;
			dry_s2 <= dry_s1;
			mix_s2 <= mix_s1;
			inv_s2 <= inv_s1;
			dry_s3 <= dry_s2;
			mix_s3 <= mix_s2;
			inv_s3 <= inv_s2;
			carrier_s4 <= carrier_s3;
			carrier_s5 <= carrier_s4;
		end
	end

	rmw_nco #(
		.PHASE_BITS(PHASE_BITS),
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_nco (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.load(load),
		.step(step_q),
		.next_shape(next_shape_q),
		.carrier(carrier_s3)
	);

	assign ctl.carrier = carrier_s3;
	assign ctl.mix = mix_s3;
	assign ctl.mix_inv = inv_s3;

	rmw_lane u_lane_left (
		.clk(clk),
		.en(en),
		.dry(dry_s3.left_in),
		.ctl(ctl),
		.sample_out(left_res)
	);

	rmw_lane u_lane_right (
		.clk(clk),
		.en(en),
		.dry(dry_s3.right_in),
		.ctl(ctl),
		.sample_out(right_res)
	);

	// Merge the two lanes and the carrier into one output word.
	always_ff @(posedge clk) begin
		if (en) begin
			result_q.left_out <= left_res;
			result_q.right_out <= right_res;
			result_q.carrier_sample <= carrier_s5;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> v_s1)
		else $error("accepted word did not enter the pipeline");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("pipeline moved during a stall");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && sample_ready |=> result_valid)
		else $error("finished word did not reach the output");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-wave stereo ring modulator. A predictor
// tracks phase, active waveform and registers, computes each blended result
// as a sample word is accepted, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module tb;

	import rmw_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_BURSTS = 40;
	localparam int FULL_POS = 32767;
	localparam int FULL_NEG = -32768;
	localparam int QUARTER_STEPS = SINE_ENTRIES_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_MAX = '1;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	class ring_mod_scoreboard;
		logic [31:0] phase_step;
		shape_t next_shape;
		shape_t active_shape;
		logic [MIX_W-1:0] wet_mix;
		logic [31:0] phase;
		int sine_quarter [0:QUARTER_STEPS];
		result_t expected_mix [$];
		int mismatches;

		function new();
			phase_step = STEP_RESET;
			next_shape = SHAPE_SINE;
			active_shape = SHAPE_SINE;
			wet_mix = MIX_ONE;
			phase = '0;
			mismatches = 0;
			for (int i = 0; i <= QUARTER_STEPS; i++) begin
				sine_quarter[i] = quarter_sine(i);
			end
		endfunction

		// Odd polynomial in Q30, divisions truncating toward zero.
		function int quarter_sine(int idx);
			longint x;
			longint x2;
			longint t;
			longint y;
			x = (longint'(idx) * Q30) / QUARTER_STEPS;
			x2 = (x * x) / Q30;
			t = C9;
			t = C7 + (t * x2) / Q30;
			t = C5 + (t * x2) / Q30;
			t = C3 + (t * x2) / Q30;
			t = C1 + (t * x2) / Q30;
			y = (t * x) / Q30;
			if (y < 0) begin
				y = 0;
			end
			y = (y * FULL_POS + Q30 / 2) / Q30;
			if (y > FULL_POS) begin
				y = FULL_POS;
			end
			return int'(y);
		endfunction

		function int carrier_of(logic [31:0] p, shape_t s);
			int t;
			int idx;
			case (s)
				SHAPE_SAW: begin
					return int'(p[31:16]) + FULL_NEG;
				end
				SHAPE_SQUARE: begin
					return p[31] ? FULL_NEG : FULL_POS;
				end
				SHAPE_TRIANGLE: begin
					t = int'(p[31:15]);
					t = p[31] ? (3 * (FULL_POS + 1)) - t : t + FULL_NEG;
					return (t > FULL_POS) ? FULL_POS : t;
				end
				default: begin
					// Quadrant 1 and 3 run the table backwards, 2 and 3 negate it.
					idx = int'(p[29:20]);
					if (p[30]) begin
						idx = QUARTER_STEPS - idx;
					end
					return p[31] ? -sine_quarter[idx] : sine_quarter[idx];
				end
			endcase
		endfunction

		function int blend(int dry, int car, int mix);
			longint acc;
			acc = longint'(dry) * (int'(MIX_ONE) - mix) * (FULL_POS + 1)
				+ longint'(dry) * car * mix;
			acc = (acc + (64'sd1 <<< 29)) >>> 30;
			if (acc > FULL_POS) begin
				acc = FULL_POS;
			end else if (acc < FULL_NEG) begin
				acc = FULL_NEG;
			end
			return int'(acc);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PHASE_STEP: phase_step = data;
				REG_NEXT_SHAPE: next_shape = shape_t'(data[1:0]);
				REG_WET_MIX: wet_mix = data[MIX_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			result_t r;
			int car;
			int mix;
			logic [32:0] sum;
			mix = (wet_mix > MIX_ONE) ? int'(MIX_ONE) : int'(wet_mix);
			car = carrier_of(phase, active_shape);
			r.left_out = 16'(blend(int'(s.left_in), car, mix));
			r.right_out = 16'(blend(int'(s.right_in), car, mix));
			r.carrier_sample = 16'(car);
			// A new waveform is picked up only on the carry out of the phase add.
			sum = {1'b0, phase} + {1'b0, phase_step};
			if (sum[32]) begin
				active_shape = next_shape;
			end
			phase = sum[31:0];
			expected_mix.push_back(r);
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_mix.size() == 0) begin
				report($sformatf("result word with nothing expected (%0d %0d %0d)",
					got.left_out, got.right_out, got.carrier_sample));
			end else begin
				want = expected_mix.pop_front();
				if (got.left_out !== want.left_out) begin
					report($sformatf("left_out got %0d want %0d", got.left_out, want.left_out));
				end
				if (got.right_out !== want.right_out) begin
					report($sformatf("right_out got %0d want %0d", got.right_out,
						want.right_out));
				end
				if (got.carrier_sample !== want.carrier_sample) begin
					report($sformatf("carrier_sample got %0d want %0d", got.carrier_sample,
						want.carrier_sample));
				end
			end
		endtask

		task finish_check();
			if (expected_mix.size() != 0) begin
				report($sformatf("%0d result words never arrived", expected_mix.size()));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	ring_mod_scoreboard sb = new();

	ring_modulator_multi_wave dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic set_idling(idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER) ? 71 : (mode == IDLE_BOTH) ? 13 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 71 : (mode == IDLE_BOTH) ? 13 : 0;
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(logic [31:0] step, logic [31:0] shape_word,
		logic [31:0] mix_word, bit spare_write);
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_NEXT_SHAPE, shape_word);
		write_reg(REG_WET_MIX, mix_word);
		if (spare_write) begin
			write_reg(8'($urandom_range(REG_INDEX_MAX, REG_WET_MIX + 1)), $urandom);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sample(sample_t s);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(s);
	endtask

	task automatic send_burst(sample_t words [$]);
		foreach (words[i]) begin
			push_sample(words[i]);
		end
		sample_valid <= 1'b0;
		while (sb.expected_mix.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic sample_t pair(int l, int r);
		sample_t s;
		s.left_in = 16'(l);
		s.right_in = 16'(r);
		return s;
	endfunction

	function automatic sample_t random_pair();
		sample_t s;
		s = sample_t'($urandom);
		if ($urandom_range(9) == 0) begin
			s.left_in = $urandom_range(1) ? 16'(FULL_POS) : 16'(FULL_NEG);
		end
		if ($urandom_range(9) == 0) begin
			s.right_in = $urandom_range(1) ? 16'(FULL_POS) : 16'(FULL_NEG);
		end
		return s;
	endfunction

	// Receiver: checks the word taken at this edge, then picks the next ready.
	initial begin
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				sb.check_result(result);
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		sample_t words [$];
		logic [31:0] step;
		logic [MIX_W-1:0] mix;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset: sine at the reset step.
		set_idling(IDLE_NONE);
		words = '{pair(FULL_POS, FULL_NEG), pair(FULL_NEG, FULL_POS), pair(0, 0),
			pair(-1, 1), pair(FULL_POS, FULL_POS), pair(FULL_NEG, FULL_NEG)};
		send_burst(words);

		// Quarter-turn step wraps every four words and brings in the saw; dry only.
		program_regs(32'h4000_0000, 32'(SHAPE_SAW), 32'd0, 1'b0);
		words = '{pair(FULL_POS, FULL_NEG), pair(FULL_NEG, FULL_POS), pair(-1, 0),
			pair(FULL_POS, 1)};
		send_burst(words);

		// Zero step holds the phase, so the triangle request never lands.
		// The mix is above one and must act as fully wet.
		program_regs(32'd0, 32'(SHAPE_TRIANGLE), 32'h0000_FFFF, 1'b0);
		words = '{pair(FULL_POS, FULL_NEG), pair(FULL_NEG, FULL_NEG), pair(1, -1)};
		send_burst(words);

		// Largest step wraps on nearly every word; a write to an unused index is ignored.
		program_regs(32'hFFFF_FFFF, 32'(SHAPE_SQUARE), 32'(MIX_ONE), 1'b1);
		words = '{pair(FULL_POS, FULL_NEG), pair(FULL_NEG, FULL_POS), pair(FULL_POS, 0),
			pair(FULL_NEG, -1)};
		send_burst(words);

		// Step of an eighth turn at half mix; the triangle lands only when the phase add wraps.
		program_regs(32'h2000_0000, 32'(SHAPE_TRIANGLE), 32'(MIX_ONE >> 1), 1'b0);
		words = '{};
		repeat (9) words.push_back(pair(FULL_POS, FULL_NEG));
		send_burst(words);

		for (int b = 0; b < RANDOM_BURSTS; b++) begin
			case ($urandom_range(9))
				0: step = '0;
				1: step = '1;
				2: step = $urandom_range(32'h0010_0000, 1);
				3: step = STEP_RESET;
				default: step = $urandom;
			endcase
			case ($urandom_range(3))
				0: mix = '0;
				1: mix = MIX_ONE;
				2: mix = 16'($urandom_range(MIX_ONE));
				default: mix = 16'($urandom);
			endcase
			program_regs(step, {30'($urandom), 2'($urandom)}, {16'($urandom), mix},
				$urandom_range(7) == 0);
			set_idling(idle_mode_t'(b % 4));
			words = '{};
			repeat ($urandom_range(40, 20)) words.push_back(random_pair());
			send_burst(words);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.finish_check();
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/rmw_pkg.sv
hdl/rmw_sine_rom.sv
hdl/rmw_nco.sv
hdl/rmw_lane.sv
hdl/ring_modulator_multi_wave.sv
test/tb.sv
